[rtl/core/ekd_pkg.sv]
`timescale 1ns / 1ps

package ekd_pkg;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int BW_W     = 31;
    localparam int KF_W     = 20;
    localparam int MAG_W    = COORD_W + 1;
    localparam int PROD_W   = BW_W + KF_W;
    localparam int OUT_FRAC = 16;
    localparam int QUO_W    = OUT_FRAC;
    localparam int SUM_W    = OUT_FRAC + 1;
    localparam int DENS_W   = OUT_FRAC + 1;
    localparam int CNT_W    = $clog2(OUT_FRAC);

    // Defaults and constants
    localparam int                FRAC_BITS_DEF = 16;
    localparam logic [KF_W-1:0]   KF_RESET      = 20'd146543;
    localparam logic [SUM_W-1:0]  SUM_MAX       = 17'd131071;
    localparam logic [SUM_W-1:0]  ONE_OUT       = 17'd65536;
    localparam logic [DENS_W-1:0] DENS_ZERO     = 17'd0;
    localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(OUT_FRAC - 1);

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture operands, form product and magnitude
        logic check;   // range check, seed remainder
        logic step;    // one restoring divide step
        logic square;  // square the quotient
        logic acc;     // add square to running sum
        logic emit;    // load output register, clear evaluation
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip;      // evaluation already out of support or quotient >= 1.0
        logic last;      // captured item closes the evaluation
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

[rtl/core/ekd_intf.sv]
`timescale 1ns / 1ps

interface ekd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ekd_pkg::COORD_W-1:0]   sample_coord;
    logic signed [ekd_pkg::COORD_W-1:0]   centre_coord;
    logic        [ekd_pkg::BW_W-1:0]      bandwidth;
    logic                                 last_dim;

    modport source (
        output valid, sample_coord, centre_coord, bandwidth, last_dim,
        input  ready
    );
    modport sink (
        input  valid, sample_coord, centre_coord, bandwidth, last_dim,
        output ready
    );
endinterface

interface ekd_out_if;
    logic                               valid;
    logic                               ready;
    logic [ekd_pkg::DENS_W-1:0]         density;
    logic                               in_support;

    modport source (
        output valid, density, in_support,
        input  ready
    );
    modport sink (
        input  valid, density, in_support,
        output ready
    );
endinterface

[rtl/core/ekd_ctrl.sv]
`timescale 1ns / 1ps

module ekd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ekd_pkg::t_stat i_stat,
    output ekd_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SQR,
        S_ACC,
        S_FIN
    } t_state;

    t_state                    r_state, n_state;
    logic [ekd_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt   = '0;
                n_state = i_stat.skip ? S_FIN : S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ekd_pkg::CNT_LAST) begin
                    n_state = S_SQR;
                end
            end
            S_SQR:   n_state = S_ACC;
            S_ACC:   n_state = S_FIN;
            S_FIN: begin
                // on the item that closes the evaluation, hold until the output register frees up
                if (!i_stat.last || i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.step   = (r_state == S_DIV);
        o_cmd.square = (r_state == S_SQR);
        o_cmd.acc    = (r_state == S_ACC);
        o_cmd.emit   = (r_state == S_FIN) && i_stat.last && i_stat.out_free;
    end

endmodule

[rtl/core/ekd_datapath.sv]
`timescale 1ns / 1ps

module ekd_datapath #(
    parameter int FRAC_BITS = ekd_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic        [ekd_pkg::KF_W-1:0]     i_cfg_data,
    input  logic signed [ekd_pkg::COORD_W-1:0]  i_sample_coord,
    input  logic signed [ekd_pkg::COORD_W-1:0]  i_centre_coord,
    input  logic        [ekd_pkg::BW_W-1:0]     i_bandwidth,
    input  logic                                i_last_dim,
    input  ekd_pkg::t_cmd                       i_cmd,
    output ekd_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [ekd_pkg::DENS_W-1:0]   o_density,
    output logic                                o_in_support
);

    localparam int PW = ekd_pkg::PROD_W;
    localparam int RW = PW + 1;
    localparam int IW = ekd_pkg::MAG_W + FRAC_BITS;
    localparam int CW = (IW > RW) ? IW : RW;

    logic [ekd_pkg::KF_W-1:0]   r_kf;
    logic [PW-1:0]              r_prod;
    logic [ekd_pkg::MAG_W-1:0]  r_mag;
    logic                       r_last;
    logic [RW-1:0]              r_rem;
    logic [ekd_pkg::QUO_W-1:0]  r_quo;
    logic [ekd_pkg::QUO_W-1:0]  r_sq;
    logic [ekd_pkg::SUM_W-1:0]  r_sum;
    logic                       r_outside;
    logic                       r_out_valid;
    logic [ekd_pkg::DENS_W-1:0] r_density;
    logic                       r_in_support;

    logic signed [ekd_pkg::MAG_W-1:0] w_diff;
    logic [ekd_pkg::MAG_W-1:0]        w_mag;
    logic [PW-1:0]                    w_prod;
    logic [CW-1:0]                    w_init;
    logic                             w_ge;
    logic [RW-1:0]                    w_shift;
    logic                             w_sub_ok;
    logic [2*ekd_pkg::QUO_W-1:0]      w_qq;
    logic [ekd_pkg::SUM_W:0]          w_t;
    logic [ekd_pkg::SUM_W-1:0]        w_sat;

    assign w_diff = ekd_pkg::MAG_W'(i_sample_coord) - ekd_pkg::MAG_W'(i_centre_coord);
    assign w_mag  = w_diff[ekd_pkg::MAG_W-1] ? ekd_pkg::MAG_W'(-w_diff)
                                             : ekd_pkg::MAG_W'(w_diff);
    assign w_prod = PW'(i_bandwidth) * PW'(r_kf);

    // quotient >= 1.0 whenever mag << FRAC_BITS reaches the product (also when it is zero)
    assign w_init = CW'(r_mag) << FRAC_BITS;
    assign w_ge   = (w_init >= CW'(r_prod));

    assign w_shift  = {r_rem[PW-1:0], 1'b0};
    assign w_sub_ok = (w_shift >= {1'b0, r_prod});

    assign w_qq  = (2*ekd_pkg::QUO_W)'(r_quo) * (2*ekd_pkg::QUO_W)'(r_quo);
    assign w_t   = {1'b0, r_sum} + (ekd_pkg::SUM_W + 1)'(r_sq);
    assign w_sat = (w_t > (ekd_pkg::SUM_W + 1)'(ekd_pkg::SUM_MAX)) ? ekd_pkg::SUM_MAX
                                                                 : w_t[ekd_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= w_prod;
            r_mag  <= w_mag;
            r_last <= i_last_dim;
        end
        if (i_cmd.check) begin
            r_rem <= w_init[RW-1:0];
            r_quo <= '0;
        end
        if (i_cmd.step) begin
            r_rem <= w_sub_ok ? (w_shift - {1'b0, r_prod}) : w_shift;
            r_quo <= {r_quo[ekd_pkg::QUO_W-2:0], w_sub_ok};
        end
        if (i_cmd.square) begin
            r_sq <= w_qq[2*ekd_pkg::QUO_W-1:ekd_pkg::OUT_FRAC];
        end
        if (i_cmd.emit) begin
            r_density    <= r_outside ? ekd_pkg::DENS_ZERO : (ekd_pkg::ONE_OUT - r_sum);
            r_in_support <= !r_outside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kf        <= ekd_pkg::KF_RESET;
            r_sum       <= '0;
            r_outside   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kf <= i_cfg_data;
            end
            if (i_cmd.check && w_ge) begin
                r_outside <= 1'b1;
            end
            if (i_cmd.acc) begin
                r_sum <= w_sat;
                if (w_sat >= ekd_pkg::ONE_OUT) begin
                    r_outside <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_sum     <= '0;
                r_outside <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.skip     = r_outside || w_ge;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_density    = r_density;
    assign o_in_support = r_in_support;

endmodule

[rtl/core/epanechnikov_kernel_density_core.sv]
`timescale 1ns / 1ps

// Unnormalized multivariate Epanechnikov kernel. Feed one dimension per item
// (sample, centre, bandwidth, all Q.FRAC_BITS); the block divides the distance
// by bandwidth * kernel_factor, squares the Q0.16 quotient and accumulates it.
// The item flagged last_dim returns one result: density = 1 - sum in Q1.16 and
// in_support = 1, or density 0 and in_support 0 once the sum reached 1.0 or a
// dimension had a quotient of 1.0 or more (a zero bandwidth or factor counts as
// outside). Other items return nothing. Each item occupies the block from accept
// to the next ready, in order: capture with the bandwidth by factor multiply,
// range check, the restoring divider, square, accumulate and finish; a
// dimension already out of support or with a quotient of 1.0 or more goes
// from the range check straight to finish. The result sits in an output
// register, so the next item is taken while a result waits; only a second
// result stalls the finish state until the first is taken. Write
// kernel_factor only while the block is idle.
module epanechnikov_kernel_density_core #(
    parameter int FRAC_BITS = ekd_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ekd_pkg::KF_W-1:0]   i_cfg_data,
    ekd_in_if.sink                     i_in,
    ekd_out_if.source                  o_out
);

    ekd_pkg::t_cmd  w_cmd;
    ekd_pkg::t_stat w_stat;

    // Sequencer: owns the input handshake and steps the datapath
    ekd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Multiplier, divider, square, accumulator and output register
    ekd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_sample_coord (i_in.sample_coord),
        .i_centre_coord (i_in.centre_coord),
        .i_bandwidth    (i_in.bandwidth),
        .i_last_dim     (i_in.last_dim),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_density      (o_out.density),
        .o_in_support   (o_out.in_support)
    );

endmodule
